[rtl/vff_pkg.sv]
package vff_pkg;

  localparam int XBits = 6;
  localparam int YBits = 6;
  localparam int ZBits = 6;
  localparam int CellBits = XBits + YBits + ZBits;
  localparam int Cells = 1 << CellBits;
  localparam int SampleBits = 16;
  localparam int CountBits = CellBits + 1;
  localparam int CfgIdxBits = 3;

  typedef logic [1:0] req_e_t;
  localparam req_e_t ReqWrite  = 2'd0;
  localparam req_e_t ReqRead   = 2'd1;
  localparam req_e_t ReqRun    = 2'd2;
  localparam req_e_t ReqUnused = 2'd3;

  localparam logic [CfgIdxBits-1:0] CfgLow   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgHigh  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgFill  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgSeedX = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgSeedY = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgSeedZ = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StReadWait,
    StClear,
    StSeed,
    StPop,
    StPopWait,
    StNbrIssue,
    StNbrWait,
    StNbrCheck,
    StResp
  } state_e;

  typedef struct packed {
    logic       do_write;
    logic       clr_start;
    logic       clr_step;
    logic       seed_mark;
    logic       pop;
    logic       pop_capture;
    logic       nbr_issue;
    logic       nbr_enter;
    logic       nbr_next;
    logic       resp_read;
    logic       resp_run;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       q_empty;
    logic       nbr_valid;
    logic       nbr_last;
    logic       nbr_ok;
    logic       seed_ok;
  } sts_t;

endpackage

[rtl/vff_ram.sv]
module vff_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/vff_ctrl.sv]
module vff_ctrl
  import vff_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  req_e_t in_type_i,
  input  logic   out_busy_i,
  input  sts_t   sts_i,
  output logic   in_ready_o,
  output cmd_t   cmd_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && !out_busy_i) begin
          case (in_type_i)
            ReqRead: state_d = StReadWait;
            ReqRun:  state_d = StClear;
            default: state_d = StIdle;
          endcase
        end
      end
      StReadWait: state_d = StIdle;
      StClear:    if (sts_i.clr_done) state_d = StSeed;
      StSeed:     state_d = sts_i.seed_ok ? StPop : StResp;
      StPop:      state_d = sts_i.q_empty ? StResp : StPopWait;
      StPopWait:  state_d = StNbrIssue;
      StNbrIssue: begin
        if (!sts_i.nbr_valid) begin
          state_d = sts_i.nbr_last ? StPop : StNbrIssue;
        end else begin
          state_d = StNbrWait;
        end
      end
      StNbrWait:  state_d = StNbrCheck;
      StNbrCheck: state_d = sts_i.nbr_last ? StPop : StNbrIssue;
      StResp:     state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = !out_busy_i;
        if (in_valid_i && !out_busy_i) begin
          cmd_o.do_write = (in_type_i == ReqWrite);
          cmd_o.clr_start = (in_type_i == ReqRun);
        end
      end
      StClear:    cmd_o.clr_step = 1'b1;
      StSeed:     cmd_o.seed_mark = 1'b1;
      StPop:      cmd_o.pop = !sts_i.q_empty;
      StPopWait:  cmd_o.pop_capture = 1'b1;
      StNbrIssue: begin
        cmd_o.nbr_issue = sts_i.nbr_valid;
        cmd_o.nbr_next = !sts_i.nbr_valid;
      end
      StNbrWait:  cmd_o.nbr_issue = 1'b1;
      StNbrCheck: begin
        cmd_o.nbr_enter = sts_i.nbr_ok;
        cmd_o.nbr_next = 1'b1;
      end
      StResp:     cmd_o.resp_run = 1'b1;
      StReadWait: cmd_o.resp_read = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[rtl/vff_dp.sv]
module vff_dp
  import vff_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [XBits-1:0]      vx_i,
  input  logic [YBits-1:0]      vy_i,
  input  logic [ZBits-1:0]      vz_i,
  input  logic [SampleBits-1:0] wsample_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [SampleBits-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output logic                  out_kind_o,
  output logic [SampleBits-1:0] out_sample_o,
  output logic [CountBits-1:0]  out_count_o
);
  logic signed [SampleBits-1:0] low_q, high_q, fill_q;
  logic [XBits-1:0] seed_x_q;
  logic [YBits-1:0] seed_y_q;
  logic [ZBits-1:0] seed_z_q;

  logic [CellBits:0]   clr_q;
  logic [CountBits-1:0] head_q, tail_q;
  logic [CellBits-1:0] cur_q, nbr_q;
  logic [2:0]          dir_q;
  logic                out_valid_q, out_kind_q;
  logic [SampleBits-1:0] out_sample_q;
  logic [CountBits-1:0]  out_count_q;

  logic [XBits-1:0] cx;
  logic [YBits-1:0] cy;
  logic [ZBits-1:0] cz;
  logic [CellBits-1:0] nbr_cell, seed_cell, req_cell;
  logic nbr_in;

  logic                  vox_we, vis_we, q_we;
  logic [CellBits-1:0]   vox_wa, vox_ra, vis_wa, vis_ra, q_wa, q_ra;
  logic [SampleBits-1:0] vox_wd, vox_rd;
  logic                  vis_wd, vis_rd;
  logic [CellBits-1:0]   q_rd;

  assign seed_cell = {seed_z_q, seed_y_q, seed_x_q};
  assign req_cell  = {vz_i, vy_i, vx_i};
  assign {cz, cy, cx} = cur_q;

  always_comb begin
    nbr_in = 1'b0;
    nbr_cell = cur_q;
    case (dir_q)
      3'd0: begin nbr_in = cx != '0;  nbr_cell = {cz, cy, cx - 1'b1}; end
      3'd1: begin nbr_in = cx != '1;  nbr_cell = {cz, cy, cx + 1'b1}; end
      3'd2: begin nbr_in = cy != '0;  nbr_cell = {cz, cy - 1'b1, cx}; end
      3'd3: begin nbr_in = cy != '1;  nbr_cell = {cz, cy + 1'b1, cx}; end
      3'd4: begin nbr_in = cz != '0;  nbr_cell = {cz - 1'b1, cy, cx}; end
      3'd5: begin nbr_in = cz != '1;  nbr_cell = {cz + 1'b1, cy, cx}; end
      default: begin nbr_in = 1'b0;   nbr_cell = cur_q; end
    endcase
  end

  assign sts_o.clr_done  = clr_q[CellBits];
  assign sts_o.q_empty   = head_q == tail_q;
  assign sts_o.nbr_valid = nbr_in;
  assign sts_o.nbr_last  = dir_q == 3'd5;
  assign sts_o.nbr_ok    = !vis_rd && ($signed(vox_rd) >= low_q)
                           && ($signed(vox_rd) <= high_q);
  assign sts_o.seed_ok   = 1'b1;

  always_comb begin
    vox_we = 1'b0;
    vox_wa = req_cell;
    vox_wd = wsample_i;
    vox_ra = req_cell;
    vis_we = 1'b0;
    vis_wa = clr_q[CellBits-1:0];
    vis_wd = 1'b0;
    vis_ra = nbr_cell;
    q_we = 1'b0;
    q_wa = tail_q[CellBits-1:0];
    q_ra = head_q[CellBits-1:0];
    if (cmd_i.do_write) begin
      vox_we = 1'b1;
    end
    if (cmd_i.nbr_issue) begin
      vox_ra = nbr_cell;
    end
    if (cmd_i.clr_step) begin
      vis_we = !clr_q[CellBits];
    end
    if (cmd_i.seed_mark) begin
      vox_we = 1'b1; vox_wa = seed_cell; vox_wd = fill_q;
      vis_we = 1'b1; vis_wa = seed_cell; vis_wd = 1'b1;
      q_we = 1'b1;   q_wa = '0;
      end
    if (cmd_i.nbr_enter) begin
      vox_we = 1'b1; vox_wa = nbr_q; vox_wd = fill_q;
      vis_we = 1'b1; vis_wa = nbr_q; vis_wd = 1'b1;
      q_we = 1'b1;
    end
  end

  vff_ram #(.Width(SampleBits), .Depth(Cells)) u_vox (
    .clk_i, .we_i(vox_we), .waddr_i(vox_wa), .wdata_i(vox_wd),
    .raddr_i(vox_ra), .rdata_o(vox_rd)
  );
  vff_ram #(.Width(1), .Depth(Cells)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .raddr_i(vis_ra), .rdata_o(vis_rd)
  );
  vff_ram #(.Width(CellBits), .Depth(Cells)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(cmd_i.seed_mark ? seed_cell : nbr_q),
    .raddr_i(q_ra), .rdata_o(q_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= '0; high_q <= '0; fill_q <= '0;
      seed_x_q <= '0; seed_y_q <= '0; seed_z_q <= '0;
      clr_q <= '0; head_q <= '0; tail_q <= '0;
      cur_q <= '0; nbr_q <= '0; dir_q <= '0;
      out_valid_q <= 1'b0; out_kind_q <= 1'b0;
      out_sample_q <= '0; out_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgLow:   low_q <= cfg_data_i;
          CfgHigh:  high_q <= cfg_data_i;
          CfgFill:  fill_q <= cfg_data_i;
          CfgSeedX: seed_x_q <= cfg_data_i[XBits-1:0];
          CfgSeedY: seed_y_q <= cfg_data_i[YBits-1:0];
          CfgSeedZ: seed_z_q <= cfg_data_i[ZBits-1:0];
          default:  ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.clr_start) clr_q <= '0;
      if (cmd_i.clr_step && !clr_q[CellBits]) clr_q <= clr_q + 1'b1;
      if (cmd_i.seed_mark) begin
        head_q <= '0;
        tail_q <= CountBits'(1);
      end
      if (cmd_i.pop) head_q <= head_q + 1'b1;
      if (cmd_i.pop_capture) begin
        cur_q <= q_rd;
        dir_q <= '0;
      end
      if (cmd_i.nbr_issue) nbr_q <= nbr_cell;
      if (cmd_i.nbr_next) dir_q <= dir_q + 1'b1;
      if (cmd_i.nbr_enter) tail_q <= tail_q + 1'b1;
      if (cmd_i.resp_read) begin
        out_valid_q <= 1'b1; out_kind_q <= 1'b0;
        out_sample_q <= vox_rd; out_count_q <= '0;
      end
      if (cmd_i.resp_run) begin
        out_valid_q <= 1'b1; out_kind_q <= 1'b1;
        out_sample_q <= '0; out_count_q <= tail_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_sample_o = out_sample_q;
  assign out_count_o  = out_count_q;
endmodule

[rtl/volume_flood_fill.sv]
// channel   | direction | payload
// s_axis    | in        | req_type, voxel_x/y/z, write_sample
// m_axis    | out       | read_sample, filled_count; tuser resp_kind
// cfg       | in        | index 0..5, data 16 bits
// write: done as the request is accepted; read: sample taken from the registered voxel memory read
// run: visited-map clear, then the seed, then per pop a check of each in-volume neighbor;
//   out-of-volume neighbors are skipped without a memory read
// one item at a time; input held off while a result waits on m_axis
// reset clears the registers; memory contents are not cleared
module volume_flood_fill
  import vff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type, voxel_x, voxel_y, voxel_z, write_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_sample, filled_count
  output logic        m_axis_tuser,   // resp_kind
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;
  logic [SampleBits-1:0] rs;
  logic [CountBits-1:0]  cnt;

  vff_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_type_i(s_axis_tdata[1:0]),
    .out_busy_i(m_axis_tvalid),
    .sts_i(sts),
    .in_ready_o(s_axis_tready),
    .cmd_o(cmd)
  );

  vff_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .vx_i(s_axis_tdata[7:2]),
    .vy_i(s_axis_tdata[13:8]),
    .vz_i(s_axis_tdata[19:14]),
    .wsample_i(s_axis_tdata[35:20]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_ready_i(m_axis_tready),
    .sts_o(sts),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o(m_axis_tuser),
    .out_sample_o(rs),
    .out_count_o(cnt)
  );

  assign m_axis_tdata = {5'd0, cnt, rs};
endmodule
